/* rtl/pidl_pkg.sv */
// Shared constants for the positional insert/delete list core.
// Request and status codes, field widths and the default list depth.
// No dependencies.
package pidl_pkg;

  localparam int unsigned DefaultDepth = 8;

  localparam int unsigned ReqW    = 2;
  localparam int unsigned PosW    = 4;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FillW   = 4;

  localparam logic [ReqW-1:0] REQ_INSERT   = 2'd0;
  localparam logic [ReqW-1:0] REQ_DELETE   = 2'd1;
  localparam logic [ReqW-1:0] REQ_TRAVERSE = 2'd2;

  localparam logic [StatusW-1:0] ST_OK     = 2'd0;
  localparam logic [StatusW-1:0] ST_BADPOS = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL   = 2'd2;
  localparam logic [StatusW-1:0] ST_EMPTY  = 2'd3;

endpackage

/* rtl/pidl_mem.sv */
// Entry store of the list: one write port, one read port, registered read data.
// Depends on pidl_pkg for the word width and the default depth.
module pidl_mem
  import pidl_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WordW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WordW-1:0] rdata_o
);

  logic [WordW-1:0] mem_q [DEPTH];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/positional_insert_delete_list_core.sv */
// Ordered list of signed words with positional insert, delete and traverse.
// Depends on pidl_pkg and pidl_mem.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------------
//   in      | input     | in_valid_i/in_ready_o | req_type_i, position_i, item_value_i
//   out     | output    | out_valid_o/out_ready_i| status_o, data_value_o, fill_count_o, last_o
//
// Entries live in a one-port-read, one-port-write RAM with registered read data.
// Insert moves one entry per cycle (none when appending), then writes the new item.
// Delete returns the entry, then moves later entries down; traverse emits one word
// per cycle unless stalled. Rejected requests only load a status. Reset clears the
// fill count, not the RAM. A stalled output holds the result and blocks new requests.
module positional_insert_delete_list_core
  import pidl_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ReqW-1:0]           req_type_i,
  input  logic [PosW-1:0]           position_i,
  input  logic signed [WordW-1:0]   item_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [StatusW-1:0]        status_o,
  output logic signed [WordW-1:0]   data_value_o,
  output logic [FillW-1:0]          fill_count_o,
  output logic                      last_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((CW > PosW) ? CW : PosW) + 1;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS_SHIFT = 3'd1;
  localparam logic [2:0] S_INS_PUT   = 3'd2;
  localparam logic [2:0] S_DEL_TAKE  = 3'd3;
  localparam logic [2:0] S_DEL_SHIFT = 3'd4;
  localparam logic [2:0] S_TRAV      = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [AW-1:0]    key_q, key_d;
  logic [AW-1:0]    lim_q, lim_d;
  logic [WordW-1:0] item_q, item_d;

  logic               ov_q, ov_d;
  logic [StatusW-1:0] st_q, st_d;
  logic [WordW-1:0]   dat_q, dat_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic               last_q, last_d;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [WordW-1:0] mem_wdata, mem_rdata;

  logic            can_load, accept;
  logic [CMPW-1:0] pos_ext, cnt_ext, pos_m1, cnt_m1, cnt_p1;

  pidl_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign can_load   = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && can_load;
  assign accept     = in_valid_i && in_ready_o;

  assign pos_ext = CMPW'(position_i);
  assign cnt_ext = CMPW'(count_q);
  assign pos_m1  = pos_ext - CMPW'(1);
  assign cnt_m1  = cnt_ext - CMPW'(1);
  assign cnt_p1  = cnt_ext + CMPW'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    addr_d    = addr_q;
    key_d     = key_q;
    lim_d     = lim_q;
    item_d    = item_q;
    ov_d      = ov_q && !out_ready_i;
    st_d      = st_q;
    dat_d     = dat_q;
    fill_d    = fill_q;
    last_d    = last_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = addr_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_INSERT: begin
              ov_d   = 1'b1;
              dat_d  = '0;
              last_d = 1'b1;
              fill_d = cnt_ext[FillW-1:0];
              if (position_i == '0 || pos_ext > cnt_p1) begin
                st_d = ST_BADPOS;
              end else if (cnt_ext == CMPW'(DEPTH)) begin
                st_d = ST_FULL;
              end else begin
                st_d    = ST_OK;
                fill_d  = cnt_p1[FillW-1:0];
                count_d = CW'(cnt_p1);
                if (pos_m1 == cnt_ext) begin
                  // append: no entries to move
                  mem_we    = 1'b1;
                  mem_waddr = pos_m1[AW-1:0];
                  mem_wdata = item_value_i;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = cnt_m1[AW-1:0];
                  addr_d    = cnt_m1[AW-1:0];
                  key_d     = pos_m1[AW-1:0];
                  item_d    = item_value_i;
                  state_d   = S_INS_SHIFT;
                end
              end
            end
            REQ_DELETE: begin
              if (position_i == '0 || pos_ext > cnt_ext) begin
                ov_d   = 1'b1;
                st_d   = ST_BADPOS;
                dat_d  = '0;
                last_d = 1'b1;
                fill_d = cnt_ext[FillW-1:0];
              end else begin
                mem_re    = 1'b1;
                mem_raddr = pos_m1[AW-1:0];
                addr_d    = pos_m1[AW-1:0];
                lim_d     = cnt_m1[AW-1:0];
                count_d   = CW'(cnt_m1);
                state_d   = S_DEL_TAKE;
              end
            end
            REQ_TRAVERSE: begin
              if (count_q == '0) begin
                ov_d   = 1'b1;
                st_d   = ST_EMPTY;
                dat_d  = '0;
                last_d = 1'b1;
                fill_d = '0;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                addr_d    = '0;
                lim_d     = cnt_m1[AW-1:0];
                state_d   = S_TRAV;
              end
            end
            default: begin
              // unused request code: drop
            end
          endcase
        end
      end
      S_INS_SHIFT: begin
        // move entry addr_q up one place, fetch the next lower one
        mem_we    = 1'b1;
        mem_waddr = addr_q + AW'(1);
        if (addr_q != key_q) begin
          mem_re    = 1'b1;
          mem_raddr = addr_q - AW'(1);
          addr_d    = addr_q - AW'(1);
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = key_q;
        mem_wdata = item_q;
        state_d   = S_IDLE;
      end
      S_DEL_TAKE: begin
        // output register is free here: it was drainable at accept
        ov_d   = 1'b1;
        st_d   = ST_OK;
        dat_d  = mem_rdata;
        last_d = 1'b1;
        fill_d = cnt_ext[FillW-1:0];
        if (addr_q != lim_q) begin
          mem_re    = 1'b1;
          mem_raddr = addr_q + AW'(1);
          addr_d    = addr_q + AW'(1);
          state_d   = S_DEL_SHIFT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DEL_SHIFT: begin
        // move entry addr_q down one place, fetch the next higher one
        mem_we    = 1'b1;
        mem_waddr = addr_q - AW'(1);
        if (addr_q != lim_q) begin
          mem_re    = 1'b1;
          mem_raddr = addr_q + AW'(1);
          addr_d    = addr_q + AW'(1);
        end else begin
          state_d = S_IDLE;
        end
      end
      S_TRAV: begin
        if (can_load) begin
          ov_d   = 1'b1;
          st_d   = ST_OK;
          dat_d  = mem_rdata;
          last_d = (addr_q == lim_q);
          fill_d = cnt_ext[FillW-1:0];
          if (addr_q == lim_q) begin
            state_d = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = addr_q + AW'(1);
            addr_d    = addr_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    key_q  <= key_d;
    lim_q  <= lim_d;
    item_q <= item_d;
    st_q   <= st_d;
    dat_q  <= dat_d;
    fill_q <= fill_d;
    last_q <= last_d;
  end

  assign out_valid_o  = ov_q;
  assign status_o     = st_q;
  assign data_value_o = dat_q;
  assign fill_count_o = fill_q;
  assign last_o       = last_q;

endmodule

/* rtl/pidl_checker.sv */
// Port-level checks for positional_insert_delete_list_core, bound to the top level.
// Depends on pidl_pkg for codes and widths.
module pidl_checker
  import pidl_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [StatusW-1:0]      status_o,
  input logic signed [WordW-1:0] data_value_o,
  input logic [FillW-1:0]        fill_count_o,
  input logic                    last_o
);

  // a stalled result holds its status, data and last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_value_o)
      && $stable(status_o) && $stable(last_o))
    else $error("stalled result changed");

  // no request is taken while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken under output stall");

  // failed requests carry zero data and end the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> data_value_o == '0 && last_o)
    else $error("failed result with data or without last");

  // fill count stays within the list depth (checked only for DEPTH up to 15)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DEPTH > 15) || (32'(fill_count_o) <= DEPTH))
    else $error("fill count above depth");

endmodule

bind positional_insert_delete_list_core pidl_checker #(.DEPTH(DEPTH)) u_pidl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .data_value_o (data_value_o),
  .fill_count_o (fill_count_o),
  .last_o       (last_o)
);
